>>> hdl/ugcb_pkg.sv
// ----------------------------------------------------------------------------
// ugcb_pkg
// Shared constants, codes, sequencer states and helpers of the grid binning core.
// ----------------------------------------------------------------------------
package ugcb_pkg;

   localparam int MAX_BALLS = 1024;
   localparam int MAX_CELLS = 4096;
   localparam int BALL_AW   = $clog2(MAX_BALLS);
   localparam int CELL_AW   = $clog2(MAX_CELLS);

   localparam int DIM_W     = 13;
   localparam int INV_W     = 24;
   localparam int COUNT_W   = 11;
   localparam int SLOT_W    = 12;
   localparam int POS_W     = 32;
   localparam int PROD_W    = 58;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_SORT  = 2'd2;
   localparam logic [1:0] MODE_START = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_GRID  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_COLS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_W = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_H = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BALLS = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHK,
      ST_EVAL,
      ST_CLR,
      ST_BIN_RD,
      ST_BIN_MX,
      ST_BIN_MY,
      ST_BIN_MC,
      ST_BIN_CELL,
      ST_BIN_INC,
      ST_PFX_RD,
      ST_PFX_WR,
      ST_SCT_RD,
      ST_SCT_CNT,
      ST_SCT_WR,
      ST_SORT_RD,
      ST_START_DATA,
      ST_RESP
   } state_type;

   function automatic logic [CELL_AW-1:0] clamp_coord(input logic signed [PROD_W-1:0] prod,
                                                       input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0]  last;
      logic [PROD_W-33:0] q;
      begin
         last = limit - DIM_W'(1);
         q    = prod[PROD_W-1:32];
         if (prod[PROD_W-1]) begin
            clamp_coord = '0;
         end else if (q > (PROD_W-32)'(last)) begin
            clamp_coord = last[CELL_AW-1:0];
         end else begin
            clamp_coord = q[CELL_AW-1:0];
         end
      end
   endfunction

endpackage

>>> hdl/uniform_grid_cell_binning_core.sv
// ----------------------------------------------------------------------------
// uniform_grid_cell_binning_core
// Loads particle positions, bins them into a uniform grid with a stable
// counting sort, and serves sorted entries and per-cell start positions.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                 tuser
//  req      in         slot, pos_x, pos_y (80 b)          mode
//  rsp      out        cell_number, ball_number,          status
//                      start_position (40 b)
//  csr      in         csr_index / csr_data write         -
//
//  Build time is set by the single count memory port and the shared
//  multiplier (three products per ball).
//  One word at a time; req_tready is low until the response word is taken.
//  Reset clears control state; cell starts read 0 until the first build.
// ----------------------------------------------------------------------------
module uniform_grid_cell_binning_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // slot[11:0], pos_x[43:12], pos_y[75:44]
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cell_number[11:0], ball_number[21:12], start[32:22]
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ugcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ugcb_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam int BA = ugcb_pkg::BALL_AW;
   localparam int CA = ugcb_pkg::CELL_AW;
   localparam int CW = ugcb_pkg::COUNT_W;
   localparam int DW = ugcb_pkg::DIM_W;
   localparam int PW = ugcb_pkg::PROD_W;

   ugcb_pkg::state_type state_ff, state_in;

   logic [DW-1:0]  cols_ff, rows_ff;
   logic [ugcb_pkg::INV_W-1:0] inv_w_ff, inv_h_ff;
   logic [CW-1:0]  balls_ff;

   logic [1:0]     mode_ff, mode_in;
   logic [11:0]    slot_ff, slot_in;
   logic [CA-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [CA-1:0]  cell_ff, cell_in;
   logic [CA-1:0]  col_ff, col_in;
   logic signed [PW-1:0] prod_ff;
   logic           built_ff, built_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CA-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [BA-1:0]  rsp_ball_ff, rsp_ball_in;
   logic [CW-1:0]  rsp_start_ff, rsp_start_in;
   logic [1:0]     rsp_stat_ff, rsp_stat_in;

   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;

   logic [DW-1:0]  cols_eff, rows_eff;
   logic [25:0]    cells;
   logic [CA-1:0]  row_v, cell_sum;
   logic [CA-1:0]  last_idx;
   logic           ball_last;

   logic           pos_we;
   logic [BA-1:0]  pos_wa, pos_ra;
   logic [63:0]    pos_rd;
   logic           cob_we;
   logic [CA-1:0]  cob_rd;
   logic           cnt_we;
   logic [CA-1:0]  cnt_wa, cnt_ra;
   logic [CW-1:0]  cnt_wd, cnt_rd;
   logic           start_we;
   logic [CW-1:0]  start_wd, start_rd;
   logic           sort_we;
   logic [BA-1:0]  sort_wa, sort_ra;
   logic [CA+BA-1:0] sort_rd;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ugcb_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_start_ff, rsp_ball_ff, rsp_cell_ff};
   assign rsp_tuser  = rsp_stat_ff;

   assign cols_eff  = (cols_ff == '0) ? DW'(1) : cols_ff;
   assign rows_eff  = (rows_ff == '0) ? DW'(1) : rows_ff;
   assign cells     = prod_ff[25:0];
   assign row_v     = ugcb_pkg::clamp_coord(prod_ff, rows_eff);
   assign cell_sum  = prod_ff[CA-1:0] + col_ff;
   assign last_idx  = CA'(ugcb_pkg::MAX_CELLS - 1);
   assign ball_last = ((idx_ff + CA'(1)) == CA'(balls_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= DW'(64);
         rows_ff  <= DW'(64);
         inv_w_ff <= 24'd65536;
         inv_h_ff <= 24'd65536;
         balls_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ugcb_pkg::REG_COLS:  cols_ff  <= csr_data[DW-1:0];
            ugcb_pkg::REG_ROWS:  rows_ff  <= csr_data[DW-1:0];
            ugcb_pkg::REG_INV_W: inv_w_ff <= csr_data;
            ugcb_pkg::REG_INV_H: inv_h_ff <= csr_data;
            ugcb_pkg::REG_BALLS: balls_ff <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ugcb_pkg::ST_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      cell_ff      <= cell_in;
      col_ff       <= col_in;
      prod_ff      <= PW'(mul_a * mul_b);
      rsp_cell_ff  <= rsp_cell_in;
      rsp_ball_ff  <= rsp_ball_in;
      rsp_start_ff <= rsp_start_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      cell_in      = cell_ff;
      col_in       = col_ff;
      built_in     = built_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_ball_in  = rsp_ball_ff;
      rsp_start_in = rsp_start_ff;
      rsp_stat_in  = rsp_stat_ff;
      mul_a        = 33'(signed'({1'b0, cols_eff}));
      mul_b        = 25'(signed'({1'b0, rows_eff}));
      pos_we       = 1'b0;
      pos_wa       = req_tdata[BA-1:0];
      pos_ra       = idx_ff[BA-1:0];
      cob_we       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wa       = idx_ff;
      cnt_wd       = '0;
      cnt_ra       = idx_ff;
      start_we     = 1'b0;
      start_wd     = (cnt_rd != '0) ? acc_ff : balls_ff;
      sort_we      = 1'b0;
      sort_wa      = cnt_rd[BA-1:0];
      sort_ra      = req_tdata[BA-1:0];

      case (state_ff)
         ugcb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in      = req_tuser;
               slot_in      = req_tdata[11:0];
               rsp_cell_in  = '0;
               rsp_ball_in  = '0;
               rsp_start_in = '0;
               rsp_stat_in  = ugcb_pkg::STAT_OK;
               case (req_tuser)
                  ugcb_pkg::MODE_LOAD: begin
                     if (req_tdata[11:BA] != '0) begin
                        rsp_stat_in = ugcb_pkg::STAT_RANGE;
                     end else begin
                        pos_we = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = ugcb_pkg::ST_RESP;
                  end
                  ugcb_pkg::MODE_SORT: begin
                     if (req_tdata[11:BA] != '0 || req_tdata[11:0] >= 12'(balls_ff)) begin
                        rsp_stat_in  = ugcb_pkg::STAT_RANGE;
                        rsp_valid_in = 1'b1;
                        state_in     = ugcb_pkg::ST_RESP;
                     end else begin
                        state_in = ugcb_pkg::ST_SORT_RD;
                     end
                  end
                  default: state_in = ugcb_pkg::ST_CHK;
               endcase
            end
         end
         ugcb_pkg::ST_CHK: begin
            state_in = ugcb_pkg::ST_EVAL;
         end
         ugcb_pkg::ST_EVAL: begin
            idx_in = '0;
            acc_in = '0;
            if (cells > 26'(ugcb_pkg::MAX_CELLS)) begin
               rsp_stat_in  = ugcb_pkg::STAT_GRID;
               rsp_valid_in = 1'b1;
               state_in     = ugcb_pkg::ST_RESP;
            end else if (mode_ff == ugcb_pkg::MODE_START) begin
               if (26'(slot_ff) >= cells) begin
                  rsp_stat_in  = ugcb_pkg::STAT_RANGE;
                  rsp_valid_in = 1'b1;
                  state_in     = ugcb_pkg::ST_RESP;
               end else begin
                  state_in = ugcb_pkg::ST_START_DATA;
               end
            end else if (balls_ff > CW'(ugcb_pkg::MAX_BALLS)) begin
               rsp_stat_in  = ugcb_pkg::STAT_RANGE;
               rsp_valid_in = 1'b1;
               state_in     = ugcb_pkg::ST_RESP;
            end else begin
               state_in = ugcb_pkg::ST_CLR;
            end
         end
         ugcb_pkg::ST_CLR: begin
            cnt_we = 1'b1;
            idx_in = idx_ff + CA'(1);
            if (idx_ff == last_idx) begin
               idx_in   = '0;
               state_in = (balls_ff == '0) ? ugcb_pkg::ST_PFX_RD : ugcb_pkg::ST_BIN_RD;
            end
         end
         ugcb_pkg::ST_BIN_RD: begin
            state_in = ugcb_pkg::ST_BIN_MX;
         end
         ugcb_pkg::ST_BIN_MX: begin
            mul_a    = 33'(signed'(pos_rd[31:0]));
            mul_b    = 25'(signed'({1'b0, inv_w_ff}));
            state_in = ugcb_pkg::ST_BIN_MY;
         end
         ugcb_pkg::ST_BIN_MY: begin
            col_in   = ugcb_pkg::clamp_coord(prod_ff, cols_eff);
            mul_a    = 33'(signed'(pos_rd[63:32]));
            mul_b    = 25'(signed'({1'b0, inv_h_ff}));
            state_in = ugcb_pkg::ST_BIN_MC;
         end
         ugcb_pkg::ST_BIN_MC: begin
            mul_a    = 33'(signed'({1'b0, row_v}));
            mul_b    = 25'(signed'({1'b0, cols_eff}));
            state_in = ugcb_pkg::ST_BIN_CELL;
         end
         ugcb_pkg::ST_BIN_CELL: begin
            cell_in  = cell_sum;
            cob_we   = 1'b1;
            cnt_ra   = cell_sum;
            state_in = ugcb_pkg::ST_BIN_INC;
         end
         ugcb_pkg::ST_BIN_INC: begin
            cnt_we = 1'b1;
            cnt_wa = cell_ff;
            cnt_wd = cnt_rd + CW'(1);
            idx_in = idx_ff + CA'(1);
            if (ball_last) begin
               idx_in   = '0;
               state_in = ugcb_pkg::ST_PFX_RD;
            end else begin
               state_in = ugcb_pkg::ST_BIN_RD;
            end
         end
         ugcb_pkg::ST_PFX_RD: begin
            state_in = ugcb_pkg::ST_PFX_WR;
         end
         ugcb_pkg::ST_PFX_WR: begin
            start_we = 1'b1;
            cnt_we   = 1'b1;
            cnt_wd   = acc_ff;
            acc_in   = acc_ff + cnt_rd;
            idx_in   = idx_ff + CA'(1);
            state_in = ugcb_pkg::ST_PFX_RD;
            if (idx_ff == last_idx) begin
               idx_in = '0;
               if (balls_ff == '0) begin
                  built_in     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ugcb_pkg::ST_RESP;
               end else begin
                  state_in = ugcb_pkg::ST_SCT_RD;
               end
            end
         end
         ugcb_pkg::ST_SCT_RD: begin
            state_in = ugcb_pkg::ST_SCT_CNT;
         end
         ugcb_pkg::ST_SCT_CNT: begin
            cell_in  = cob_rd;
            cnt_ra   = cob_rd;
            state_in = ugcb_pkg::ST_SCT_WR;
         end
         ugcb_pkg::ST_SCT_WR: begin
            cnt_we  = 1'b1;
            cnt_wa  = cell_ff;
            cnt_wd  = cnt_rd + CW'(1);
            sort_we = 1'b1;
            idx_in  = idx_ff + CA'(1);
            if (ball_last) begin
               built_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ugcb_pkg::ST_RESP;
            end else begin
               state_in = ugcb_pkg::ST_SCT_RD;
            end
         end
         ugcb_pkg::ST_SORT_RD: begin
            rsp_cell_in  = sort_rd[CA+BA-1:BA];
            rsp_ball_in  = sort_rd[BA-1:0];
            rsp_valid_in = 1'b1;
            state_in     = ugcb_pkg::ST_RESP;
         end
         ugcb_pkg::ST_START_DATA: begin
            rsp_start_in = built_ff ? start_rd : '0;
            rsp_valid_in = 1'b1;
            state_in     = ugcb_pkg::ST_RESP;
         end
         ugcb_pkg::ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ugcb_pkg::ST_IDLE;
            end
         end
         default: state_in = ugcb_pkg::ST_IDLE;
      endcase
   end

   ugcb_ram #(.DEPTH(ugcb_pkg::MAX_BALLS), .WIDTH(64)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_wa),
      .wr_data ({req_tdata[75:44], req_tdata[43:12]}),
      .rd_addr (pos_ra),
      .rd_data (pos_rd)
   );

   ugcb_ram #(.DEPTH(ugcb_pkg::MAX_BALLS), .WIDTH(CA)) u_cob_ram (
      .clock   (clock),
      .wr_en   (cob_we),
      .wr_addr (idx_ff[BA-1:0]),
      .wr_data (cell_sum),
      .rd_addr (idx_ff[BA-1:0]),
      .rd_data (cob_rd)
   );

   ugcb_ram #(.DEPTH(ugcb_pkg::MAX_CELLS), .WIDTH(CW)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (cnt_ra),
      .rd_data (cnt_rd)
   );

   ugcb_ram #(.DEPTH(ugcb_pkg::MAX_CELLS), .WIDTH(CW)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (idx_ff),
      .wr_data (start_wd),
      .rd_addr (slot_ff[CA-1:0]),
      .rd_data (start_rd)
   );

   ugcb_ram #(.DEPTH(ugcb_pkg::MAX_BALLS), .WIDTH(CA+BA)) u_sort_ram (
      .clock   (clock),
      .wr_en   (sort_we),
      .wr_addr (sort_wa),
      .wr_data ({cell_ff, idx_ff[BA-1:0]}),
      .rd_addr (sort_ra),
      .rd_data (sort_rd)
   );

endmodule

>>> hdl/ugcb_ram.sv
// ----------------------------------------------------------------------------
// ugcb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ugcb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid binning core: loads positions, builds cell
// lists under several grid setups and checks every response word against an
// in-bench counting-sort predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      logic [11:0] cell_id;
      logic [9:0]  ball;
      logic [10:0] start;
      logic [1:0]  status;
   } bin_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [ugcb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ugcb_pkg::CSR_DAT_W-1:0] csr_data = '0;

   uniform_grid_cell_binning_core dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [12:0] grid_cols, grid_rows;
   logic [23:0] inv_w, inv_h;
   logic [10:0] ball_total;
   logic [31:0] pos_x_mem [ugcb_pkg::MAX_BALLS];
   logic [31:0] pos_y_mem [ugcb_pkg::MAX_BALLS];
   logic [11:0] sorted_cell_mem [ugcb_pkg::MAX_BALLS];
   logic [9:0]  sorted_ball_mem [ugcb_pkg::MAX_BALLS];
   logic [10:0] cell_start_mem [ugcb_pkg::MAX_CELLS];
   int          sorted_written;

   bin_word_type expected_words [$];
   int  errors = 0;
   int  items_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_start = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   function automatic int eff_dim(logic [12:0] d);
      return (d == 0) ? 1 : int'(d);
   endfunction

   function automatic int grid_cells();
      return eff_dim(grid_cols) * eff_dim(grid_rows);
   endfunction

   function automatic int bin_coord(logic [31:0] p, logic [23:0] inv, int limit);
      longint prod;
      longint q;
      prod = longint'($signed(p)) * longint'(inv);
      if (prod < 0) return 0;
      q = prod >>> 32;
      if (q > limit - 1) return limit - 1;
      return int'(q);
   endfunction

   function automatic logic [1:0] sort_into_cells();
      int cols, rows, n, acc, c, p;
      int counts [ugcb_pkg::MAX_CELLS];
      int cell_of [ugcb_pkg::MAX_BALLS];
      cols = eff_dim(grid_cols);
      rows = eff_dim(grid_rows);
      n = ball_total;
      if (cols * rows > ugcb_pkg::MAX_CELLS) return ugcb_pkg::STAT_GRID;
      if (n > ugcb_pkg::MAX_BALLS) return ugcb_pkg::STAT_RANGE;
      foreach (counts[i]) counts[i] = 0;
      for (int i = 0; i < n; i++) begin
         c = bin_coord(pos_y_mem[i], inv_h, rows) * cols + bin_coord(pos_x_mem[i], inv_w, cols);
         cell_of[i] = c;
         counts[c]++;
      end
      acc = 0;
      for (int i = 0; i < ugcb_pkg::MAX_CELLS; i++) begin
         cell_start_mem[i] = (counts[i] != 0) ? 11'(acc) : 11'(n);
         c = counts[i];
         counts[i] = acc;
         acc += c;
      end
      for (int i = 0; i < n; i++) begin
         p = counts[cell_of[i]];
         counts[cell_of[i]] = p + 1;
         sorted_cell_mem[p] = 12'(cell_of[i]);
         sorted_ball_mem[p] = 10'(i);
      end
      if (n > sorted_written) sorted_written = n;
      return ugcb_pkg::STAT_OK;
   endfunction

   function automatic bin_word_type predict_word(logic [1:0] mode, logic [11:0] slot,
                                                 logic [31:0] x, logic [31:0] y);
      bin_word_type w;
      w = '0;
      case (mode)
         ugcb_pkg::MODE_LOAD: begin
            if (slot >= ugcb_pkg::MAX_BALLS) w.status = ugcb_pkg::STAT_RANGE;
            else begin
               pos_x_mem[slot[9:0]] = x;
               pos_y_mem[slot[9:0]] = y;
            end
         end
         ugcb_pkg::MODE_BUILD: w.status = sort_into_cells();
         ugcb_pkg::MODE_SORT: begin
            if (slot >= ball_total || slot >= ugcb_pkg::MAX_BALLS)
               w.status = ugcb_pkg::STAT_RANGE;
            else begin
               w.cell_id = sorted_cell_mem[slot[9:0]];
               w.ball    = sorted_ball_mem[slot[9:0]];
            end
         end
         default: begin
            if (grid_cells() > ugcb_pkg::MAX_CELLS) w.status = ugcb_pkg::STAT_GRID;
            else if (slot >= grid_cells()) w.status = ugcb_pkg::STAT_RANGE;
            else w.start = cell_start_mem[slot];
         end
      endcase
      return w;
   endfunction

   task automatic send_word(logic [1:0] mode, int slot,
                            logic [31:0] x = '0, logic [31:0] y = '0);
      expected_words.push_back(predict_word(mode, slot[11:0], x, y));
      items_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, y, x, slot[11:0]};
      req_tuser  <= mode;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [ugcb_pkg::CSR_IDX_W-1:0] idx, int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[23:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ugcb_pkg::REG_COLS:  grid_cols  = value[12:0];
         ugcb_pkg::REG_ROWS:  grid_rows  = value[12:0];
         ugcb_pkg::REG_INV_W: inv_w      = value[23:0];
         ugcb_pkg::REG_INV_H: inv_h      = value[23:0];
         ugcb_pkg::REG_BALLS: ball_total = value[10:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(int cols, int rows, int iw, int ih, int n);
      write_reg(ugcb_pkg::REG_COLS, cols);
      write_reg(ugcb_pkg::REG_ROWS, rows);
      write_reg(ugcb_pkg::REG_INV_W, iw);
      write_reg(ugcb_pkg::REG_INV_H, ih);
      write_reg(ugcb_pkg::REG_BALLS, n);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3:       return -$urandom_range(0, 32'h00FFFFFF);
         default: return $urandom_range(0, 32'h00500000);
      endcase
   endfunction

   // in-range sorted reads stay within entries some build has written; others are at or above ball_total
   function automatic logic [11:0] sort_slot();
      int lim;
      lim = (ball_total < sorted_written) ? ball_total : sorted_written;
      if (lim > 0 && $urandom_range(3) != 0) return 12'($urandom_range(0, lim - 1));
      return 12'($urandom_range(ball_total, 4095));
   endfunction

   task automatic test_reset_state();
      send_word(ugcb_pkg::MODE_START, 5);
      send_word(ugcb_pkg::MODE_SORT, 0);
      send_word(ugcb_pkg::MODE_LOAD, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_START, 4095);
   endtask

   task automatic test_directed_bins();
      logic [31:0] xs [8];
      logic [31:0] ys [8];
      xs = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
             32'h0003_FFFF, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0001_0000};
      ys = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_C000,
             32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000};
      set_grid(4, 3, 65536, 65536, 8);
      for (int i = 0; i < 8; i++) send_word(ugcb_pkg::MODE_LOAD, i, xs[i], ys[i]);
      send_word(ugcb_pkg::MODE_BUILD, 12'hABC);
      for (int i = 0; i < 9; i++) send_word(ugcb_pkg::MODE_SORT, i);
      for (int i = 0; i < 13; i++) send_word(ugcb_pkg::MODE_START, i);
      // oversize grid, too many balls, zero dimensions, extreme scales
      set_grid(4096, 2, 24'hFFFFFF, 0, 1024);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_START, 0);
      set_grid(4096, 1, 24'hFFFFFF, 0, 2047);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_SORT, 7);
      write_reg(ugcb_pkg::REG_BALLS, 8);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_START, 4095);
      send_word(ugcb_pkg::MODE_SORT, 3);
      set_grid(0, 0, 0, 24'hFFFFFF, 1025);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      write_reg(ugcb_pkg::REG_BALLS, 8);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_START, 0);
      send_word(ugcb_pkg::MODE_START, 1);
      set_grid(1, 4096, 65536, 24'hFFFFFF, 8);
      send_word(ugcb_pkg::MODE_BUILD, 0);
      send_word(ugcb_pkg::MODE_START, 4095);
      set_grid(8191, 8191, 65536, 65536, 8);
      send_word(ugcb_pkg::MODE_START, 3);
   endtask

   task automatic run_bin_phase(int phase);
      int cols, rows, n, iw, ih, cells;
      case (phase % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
         default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      cols = $urandom_range(1, 64);
      rows = $urandom_range(1, 64);
      n = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      iw = ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 24'h40000);
      ih = ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 24'h40000);
      set_grid(cols, rows, iw, ih, n);
      cells = grid_cells();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            send_word(ugcb_pkg::MODE_LOAD, $urandom_range(1024, 4095), $urandom, $urandom);
         send_word(ugcb_pkg::MODE_LOAD, i, rand_pos(), rand_pos());
      end
      send_word(ugcb_pkg::MODE_BUILD, $urandom_range(0, 4095));
      repeat (n + 10) begin
         case ($urandom_range(7))
            0, 1, 2, 3: send_word(ugcb_pkg::MODE_SORT, sort_slot());
            4, 5:       send_word(ugcb_pkg::MODE_START, $urandom_range(0, cells - 1));
            6:          send_word(ugcb_pkg::MODE_START, $urandom_range(0, 4095));
            default:    send_word(ugcb_pkg::MODE_LOAD, $urandom_range(1024, 4095),
                                  $urandom, $urandom);
         endcase
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_start = 1;
      repeat (20) send_word(ugcb_pkg::MODE_START, $urandom_range(0, grid_cells() - 1));
      repeat (10) send_word(ugcb_pkg::MODE_SORT, sort_slot());
   endtask

   always @(posedge clock) begin
      bin_word_type exp_w;
      if (hold_start) begin
         hold_left = 400;
         hold_start = 0;
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected response word %h / %h", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_tdata[11:0] !== exp_w.cell_id) begin
               $error("cell_number expected %0d actual %0d", exp_w.cell_id, rsp_tdata[11:0]);
               errors++;
            end
            if (rsp_tdata[21:12] !== exp_w.ball) begin
               $error("ball_number expected %0d actual %0d", exp_w.ball, rsp_tdata[21:12]);
               errors++;
            end
            if (rsp_tdata[32:22] !== exp_w.start) begin
               $error("start_position expected %0d actual %0d", exp_w.start, rsp_tdata[32:22]);
               errors++;
            end
            if (rsp_tuser !== exp_w.status) begin
               $error("status expected %0d actual %0d", exp_w.status, rsp_tuser);
               errors++;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      grid_cols = 64;
      grid_rows = 64;
      inv_w = 65536;
      inv_h = 65536;
      ball_total = 0;
      sorted_written = 0;
      foreach (cell_start_mem[i]) cell_start_mem[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_bins();
      for (int phase = 0; items_sent < 1250; phase++) begin
         run_bin_phase(phase);
         if (phase == 5) test_backpressure();
      end
      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/ugcb_pkg.sv
hdl/ugcb_ram.sv
hdl/uniform_grid_cell_binning_core.sv
tb/sv/tb.sv
